// ===== rtl/sine_oscillator_with_fade_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sine oscillator with fade
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SINE_OSCILLATOR_WITH_FADE_UNIT_DEFINES_SVH
`define SINE_OSCILLATOR_WITH_FADE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOFU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SOFU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The condition must never be true.
`define SOFU_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/sofu_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine oscillator with fade: shared package
// Field widths, register indexes, ramp codes, controller/datapath structs
// and the quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package sofu_pkg;

	// Field widths.
	localparam int IDX_W    = 10;
	localparam int CNT_W    = 11;
	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 32;
	localparam int AMP_W    = 16;
	localparam int CFG_W    = 32;
	localparam int MAG_W    = 15;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 1'd1;
	localparam logic [AMP_W-1:0]     AMP_RESET      = 16'd32768;

	// Quarter-wave table geometry.
	localparam int SINE_DEPTH = 256;
	localparam int SINE_AW    = $clog2(SINE_DEPTH);

	// Product and divider widths.
	localparam int PROD_W = MAG_W + AMP_W;          // magnitude times amplitude
	localparam int NUM_W  = PROD_W + CNT_W + 1;     // times ramp numerator, plus rounding
	localparam int DIVD_W = NUM_W - 15;             // dividend after the Q15 shift
	localparam int QUO_W  = DIVD_W - CNT_W;         // quotient bits the divider produces
	localparam int DIV_STEPS = QUO_W;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	// Ramp codes chosen by the controller for each word.
	localparam logic [1:0] RAMP_NONE = 2'd0;
	localparam logic [1:0] RAMP_RISE = 2'd1;
	localparam logic [1:0] RAMP_FALL = 2'd2;
	localparam logic [1:0] RAMP_MUTE = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic [1:0] ramp;
		logic       mul1;
		logic       mul2;
		logic       div_step;
		logic       out_load;
	} sofu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic c_one;
	} sofu_sts_t;

	// Polynomial coefficients in Q30.
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] C1 = 64'd1686629713;
	localparam logic [63:0] C3 = 64'd693598668;
	localparam logic [63:0] C5 = 64'd85569306;
	localparam logic [63:0] C7 = 64'd5026997;
	localparam logic [63:0] C9 = 64'd172272;

	typedef logic [MAG_W-1:0] sine_rom_t [SINE_DEPTH];

	// One table entry: sin(pi/2 * k/D) in Q15 by a Horner polynomial in Q30.
	function automatic logic [MAG_W-1:0] sine_entry(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = (64'(k) << 30) / SINE_DEPTH;
		x2 = (x * x) >> 30;
		t  = C7 - ((x2 * C9) >> 30);
		t  = C5 - ((x2 * t) >> 30);
		t  = C3 - ((x2 * t) >> 30);
		t  = C1 - ((x2 * t) >> 30);
		t  = (x * t) >> 30;
		t  = (t * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		if (t > 64'd32767) begin
			t = 64'd32767;
		end
		return t[MAG_W-1:0];
	endfunction

	function automatic sine_rom_t sine_rom_init();
		sine_rom_t r;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			r[k] = sine_entry(k);
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = sine_rom_init();

endpackage

// ===== rtl/sofu_channels.sv =====
// ----------------------------------------------------------------------------
// Sine oscillator with fade: channel interfaces
// Valid/ready channels for sample slot requests and output samples.
// ----------------------------------------------------------------------------

// Sample slot request channel.
interface sofu_in_if;
	import sofu_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] sample_index;
	logic [CNT_W-1:0] frame_count;
	logic             wave_on;

	modport source(output valid, sample_index, frame_count, wave_on, input ready);
	modport sink(input valid, sample_index, frame_count, wave_on, output ready);
endinterface

// Output sample channel.
interface sofu_out_if;
	import sofu_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source(output valid, sample, input ready);
	modport sink(input valid, sample, output ready);
endinterface

// ===== rtl/sine_oscillator_with_fade_unit.sv =====
// ----------------------------------------------------------------------------
// Sine oscillator with fade
// Phase-accumulator sine generator with fade-in and fade-out ramps over one
// block of sample slots.
//
//   channel   dir  handshake       word
//   in_ch     in   valid/ready     sample_index, frame_count, wave_on
//   out_ch    out  valid/ready     sample
//   cfg       in   cfg_we          cfg_index, cfg_wdata
//
// A slot runs load, two multiplies and output when the ramp denominator is
// one, and adds the 17-step restoring divider before the output otherwise.
// One slot is in flight at a time; the next is taken once the current one
// reaches the output register, even if that word is still waiting.
// arst_n clears the phase, fade flags, phase step and output valid flag; amplitude resets to AMP_RESET.
// A stalled output holds the word and the last slot waits in its final step.
// ----------------------------------------------------------------------------
module sine_oscillator_with_fade_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sofu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sofu_pkg::CFG_W-1:0]      cfg_wdata,
	sofu_in_if.sink                         in_ch,
	sofu_out_if.source                      out_ch
);
	import sofu_pkg::*;

	sofu_cmd_t cmd;
	sofu_sts_t sts;

	// Sequencing and fade state.
	sofu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.sample_index (in_ch.sample_index),
		.frame_count  (in_ch.frame_count),
		.wave_on      (in_ch.wave_on),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	// Arithmetic.
	sofu_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.sample_index (in_ch.sample_index),
		.frame_count  (in_ch.frame_count),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (out_ch.sample)
	);

endmodule

// ===== rtl/sofu_datapath.sv =====
// ----------------------------------------------------------------------------
// Sine oscillator with fade: datapath
// Phase accumulator, table lookup, two multiplies, a radix-2 restoring
// divider for the ramp and the saturating output register.
// ----------------------------------------------------------------------------
module sofu_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sofu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sofu_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic [sofu_pkg::IDX_W-1:0]          sample_index,
	input  logic [sofu_pkg::CNT_W-1:0]          frame_count,
	input  sofu_pkg::sofu_cmd_t                 cmd,
	output sofu_pkg::sofu_sts_t                 sts,
	output logic signed [sofu_pkg::SAMPLE_W-1:0] sample
);
	import sofu_pkg::*;

	logic [PHASE_W-1:0]  phase_step_q;
	logic [AMP_W-1:0]    amplitude_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [MAG_W-1:0]    mag_q;
	logic                neg_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    c_q;
	logic [PROD_W-1:0]   prod_q;
	logic [CNT_W-1:0]    rem_q;
	logic [QUO_W-1:0]    quo_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic [SINE_AW-1:0]  tab_i;
	logic [SINE_AW:0]    tab_mirror;
	logic [SINE_AW-1:0]  tab_sel;
	logic                tab_top;
	logic [MAG_W-1:0]    mag_d;
	logic [CNT_W-1:0]    n_d;
	logic [CNT_W-1:0]    c_d;
	logic [CNT_W:0]      idx_ext;
	logic                cnt_nz;
	logic                idx_lt;
	logic [NUM_W-1:0]    num;
	logic [DIVD_W-1:0]   dividend;
	logic [CNT_W:0]      trial;
	logic [CNT_W:0]      trial_diff;
	logic                trial_ge;
	logic signed [SAMPLE_W-1:0] sat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			amplitude_q  <= AMP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_STEP: phase_step_q <= cfg_wdata;
				REG_AMPLITUDE:  amplitude_q  <= cfg_wdata[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// Quarter-wave lookup: odd quadrants read the mirrored entry.
	always_comb begin
		tab_i      = phase_q[PHASE_W-3 -: SINE_AW];
		tab_mirror = (SINE_AW+1)'(SINE_DEPTH) - {1'b0, tab_i};
		tab_top    = phase_q[PHASE_W-2] && (tab_i == '0);
		tab_sel    = phase_q[PHASE_W-2] ? tab_mirror[SINE_AW-1:0] : tab_i;
		mag_d      = tab_top ? MAG_W'(32767) : SINE_ROM[tab_sel];
	end

	// Ramp numerator and denominator.
	always_comb begin
		idx_ext = {2'b00, sample_index};
		cnt_nz  = (frame_count != '0);
		idx_lt  = (idx_ext < {1'b0, frame_count});
		n_d     = CNT_W'(1);
		c_d     = CNT_W'(1);
		case (cmd.ramp)
			RAMP_RISE: begin
				n_d = idx_lt ? idx_ext[CNT_W-1:0] : frame_count;
				c_d = frame_count;
			end
			RAMP_FALL: begin
				n_d = (cnt_nz && idx_lt) ? CNT_W'(frame_count - idx_ext[CNT_W-1:0]) : '0;
				c_d = cnt_nz ? frame_count : CNT_W'(1);
			end
			RAMP_MUTE: begin
				n_d = '0;
			end
			default: ;
		endcase
	end

	// Word load: capture the magnitude and ramp, and advance the phase unless muted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.load && (cmd.ramp != RAMP_MUTE)) begin
			phase_q <= phase_q + phase_step_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_d;
			neg_q <= phase_q[PHASE_W-1];
			n_q   <= n_d;
			c_q   <= c_d;
		end
	end

	// Second multiply with half-LSB rounding, then the Q15 shift.
	always_comb begin
		num      = {(NUM_W-PROD_W)'(0), prod_q} * {(NUM_W-CNT_W)'(0), n_q}
		         + {(NUM_W-CNT_W-14)'(0), c_q, 14'd0};
		dividend = num[NUM_W-1:15];
	end

	// One restoring divide step.
	always_comb begin
		trial      = {rem_q, quo_q[QUO_W-1]};
		trial_diff = trial - {1'b0, c_q};
		trial_ge   = (trial >= {1'b0, c_q});
	end

	// Multiplier and divider registers.
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			prod_q <= {(PROD_W-MAG_W)'(0), mag_q} * {(PROD_W-AMP_W)'(0), amplitude_q};
		end
		if (cmd.mul2) begin
			rem_q <= dividend[DIVD_W-1:QUO_W];
			quo_q <= dividend[QUO_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], trial_ge};
		end
	end

	// Sign and saturation.
	always_comb begin
		if (neg_q) begin
			if (quo_q >= QUO_W'(32768)) begin
				sat = 16'sh8000;
			end else begin
				sat = SAMPLE_W'(16'd0 - quo_q[SAMPLE_W-1:0]);
			end
		end else begin
			if (quo_q > QUO_W'(32767)) begin
				sat = 16'sh7fff;
			end else begin
				sat = quo_q[SAMPLE_W-1:0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_q <= sat;
		end
	end

	assign sts.c_one = (c_q == CNT_W'(1));
	assign sample    = sample_q;

endmodule

// ===== rtl/sofu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sine oscillator with fade: controller
// Sequences load, multiplies and divide steps, keeps the fade flags and the
// output valid flag.
// ----------------------------------------------------------------------------
`include "sine_oscillator_with_fade_unit_defines.svh"

module sofu_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sofu_pkg::IDX_W-1:0]  sample_index,
	input  logic [sofu_pkg::CNT_W-1:0]  frame_count,
	input  logic                        wave_on,
	output logic                        out_valid,
	input  logic                        out_ready,
	output sofu_pkg::sofu_cmd_t         cmd,
	input  sofu_pkg::sofu_sts_t         sts
);
	import sofu_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_MUL2 = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [DCNT_W-1:0] dcnt_q;
	logic              faded_in_q;
	logic              faded_out_q;
	logic              out_valid_q;
	logic              accept;
	logic              last_slot;
	logic [1:0]        ramp;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// Ramp choice from the request and the fade flags.
	always_comb begin
		last_slot = (frame_count != '0) && (({1'b0, sample_index} + CNT_W'(1)) == frame_count);
		if (wave_on) begin
			ramp = (!faded_in_q && (frame_count != '0)) ? RAMP_RISE : RAMP_NONE;
		end else if (!faded_out_q) begin
			ramp = RAMP_FALL;
		end else begin
			ramp = RAMP_MUTE;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.ramp     = ramp;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = sts.c_one ? S_DONE : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (dcnt_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, divide counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL2) begin
				dcnt_q <= DCNT_W'(DIV_STEPS - 1);
			end else if (state_q == S_DIV) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Fade flags change only on the last slot of a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faded_in_q  <= 1'b0;
			faded_out_q <= 1'b0;
		end else if (accept && last_slot) begin
			if (wave_on) begin
				faded_in_q  <= 1'b1;
				faded_out_q <= 1'b0;
			end else if (!faded_out_q) begin
				faded_out_q <= 1'b1;
				faded_in_q  <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`SOFU_ASSERT_NEVER(a_flags_exclusive, faded_in_q && faded_out_q, "both fade flags set")
	`SOFU_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_q || out_ready, "output word overwritten")
	`SOFU_ASSERT_NXT(a_accept_starts, accept, state_q == S_MUL1 && !in_ready, "accept did not start work")
	`SOFU_ASSERT_NXT(a_div_ends, state_q == S_DIV && dcnt_q == '0, state_q == S_DONE, "divide overran")

endmodule

// ===== dv/sofu_sample_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sample checker for the sine oscillator with fade
// Watches the slot and sample channels and the register port. It keeps its
// own phase, fade flags and register copies, works out the sample each
// accepted slot must produce, and compares the output words in order.
// ----------------------------------------------------------------------------
module sofu_sample_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sofu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sofu_pkg::CFG_W-1:0]      cfg_wdata,
	sofu_in_if                              in_mon,
	sofu_out_if                             out_mon,
	output int                              fail_count,
	output int                              pending_count,
	output int                              words_checked,
	output int                              ramp_words
);
	import sofu_pkg::*;

	localparam int QUARTER_DEPTH = 256;
	localparam logic [63:0] Q30_UNIT = 64'd1073741824;

	// Quarter-wave sine magnitudes in Q15.
	logic [14:0] quarter_sine [QUARTER_DEPTH];

	// Tracked oscillator state and register copies.
	logic [31:0] phase_acc   = '0;
	logic        faded_in    = 1'b0;
	logic        faded_out   = 1'b0;
	logic [31:0] step_reg    = '0;
	logic [15:0] gain_reg    = AMP_RESET;

	logic signed [SAMPLE_W-1:0] expected_samples [$];
	int mismatches = 0;
	int checked    = 0;
	int ramped     = 0;

	// Odd polynomial for sin(pi/2 * k/D), evaluated in Q30 and rounded to Q15.
	function automatic logic [14:0] quarter_sine_q15(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		x   = (64'(k) << 30) / QUARTER_DEPTH;
		x2  = (x * x) >> 30;
		acc = 64'd5026997 - ((x2 * 64'd172272) >> 30);
		acc = 64'd85569306 - ((x2 * acc) >> 30);
		acc = 64'd693598668 - ((x2 * acc) >> 30);
		acc = 64'd1686629713 - ((x2 * acc) >> 30);
		acc = (x * acc) >> 30;
		acc = (acc * 64'd32767 + (Q30_UNIT >> 1)) >> 30;
		if (acc > 64'd32767) begin
			acc = 64'd32767;
		end
		return acc[14:0];
	endfunction

	initial begin
		for (int k = 0; k < QUARTER_DEPTH; k++) begin
			quarter_sine[k] = quarter_sine_q15(k);
		end
	end

	// Sample for one slot; advances the phase and the fade flags as the block does.
	function automatic logic signed [SAMPLE_W-1:0] predict_sample(
		input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] cnt,
		input logic             on
	);
		logic [63:0] ramp_num;
		logic [63:0] ramp_den;
		logic [63:0] mag;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		logic [1:0]  quad;
		logic [7:0]  slot;
		logic        last;
		logic        active;
		logic signed [SAMPLE_W-1:0] res;
		last     = (cnt != 0) && (CNT_W'(idx) + 11'd1 == cnt);
		ramp_num = 64'd1;
		ramp_den = 64'd1;
		active   = 1'b0;
		res      = '0;

		// Pick the ramp: rising on the first block after turning on, falling
		// on the first block after turning off, none once settled.
		if (on) begin
			active = 1'b1;
			if (!faded_in && cnt != 0) begin
				ramp_num = (64'(idx) < 64'(cnt)) ? 64'(idx) : 64'(cnt);
				ramp_den = 64'(cnt);
			end
		end else if (!faded_out) begin
			active   = 1'b1;
			ramp_num = (cnt != 0 && 64'(idx) < 64'(cnt)) ? 64'(cnt) - 64'(idx) : 64'd0;
			ramp_den = (cnt != 0) ? 64'(cnt) : 64'd1;
		end

		if (active) begin
			quad = phase_acc[31:30];
			slot = phase_acc[29:22];
			// Odd quadrants mirror the table; the mirror of entry zero is full scale.
			if (quad[0]) begin
				mag = (slot == 0) ? 64'd32767 : 64'(quarter_sine[QUARTER_DEPTH - int'(slot)]);
			end else begin
				mag = 64'(quarter_sine[slot]);
			end
			num = mag * 64'(gain_reg) * ramp_num;
			den = ramp_den << 15;
			q   = (num * 2 + den) / (den * 2);
			if (quad[1]) begin
				if (q > 64'd32768) begin
					q = 64'd32768;
				end
				res = SAMPLE_W'(64'd0 - q);
			end else begin
				if (q > 64'd32767) begin
					q = 64'd32767;
				end
				res = SAMPLE_W'(q);
			end
			phase_acc = phase_acc + step_reg;
			if (!(ramp_num == 1 && ramp_den == 1)) begin
				ramped++;
			end
		end

		// Flags move only on the last slot of a block.
		if (last) begin
			if (on) begin
				faded_in  = 1'b1;
				faded_out = 1'b0;
			end else if (!faded_out) begin
				faded_out = 1'b1;
				faded_in  = 1'b0;
			end
		end
		return res;
	endfunction

	// Track writes, predict on each accepted slot, compare each accepted word.
	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			phase_acc = '0;
			faded_in  = 1'b0;
			faded_out = 1'b0;
			step_reg  = '0;
			gain_reg  = AMP_RESET;
			expected_samples.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PHASE_STEP: step_reg = cfg_wdata;
					REG_AMPLITUDE:  gain_reg = cfg_wdata[AMP_W-1:0];
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				expected_samples.push_back(
					predict_sample(in_mon.sample_index, in_mon.frame_count, in_mon.wave_on));
			end
			if (out_mon.valid && out_mon.ready) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("checker: unexpected sample word %0d with nothing pending",
							out_mon.sample);
					end
				end else begin
					want = expected_samples.pop_front();
					if (out_mon.sample !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("checker: sample word %0d: expected %0d, got %0d",
								checked, want, out_mon.sample);
						end
					end
					checked++;
				end
			end
		end
		fail_count    <= mismatches;
		pending_count <= expected_samples.size();
		words_checked <= checked;
		ramp_words    <= ramped;
	end

endmodule

// ===== dv/tb_sine_oscillator_with_fade_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sine oscillator with fade
// Drives sample slots in blocks across several phase step and amplitude
// settings, with random gaps on the slot side and random stalls on the
// sample side; the sample checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_sine_oscillator_with_fade_unit;
	import sofu_pkg::*;

	localparam int CYCLE_LIMIT    = 600000;
	localparam int RANDOM_PHASES  = 8;
	localparam int SLOTS_PER_PHASE = 176;
	localparam int DRAIN_CYCLES   = 30;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PHASE_STEP;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	sofu_in_if  in_ch();
	sofu_out_if out_ch();

	int fail_count;
	int pending_count;
	int words_checked;
	int ramp_words;
	int slots_sent    = 0;
	int settings_used = 0;
	int cycle_count   = 0;
	bit no_gaps       = 1'b0;

	sine_oscillator_with_fade_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	sofu_sample_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_mon        (in_ch),
		.out_mon       (out_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.words_checked (words_checked),
		.ramp_words    (ramp_words)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Known values on every input from time zero.
	initial begin
		in_ch.valid        = 1'b0;
		in_ch.sample_index = '0;
		in_ch.frame_count  = '0;
		in_ch.wave_on      = 1'b0;
		out_ch.ready       = 1'b0;
	end

	// Sample side: stalls at random except during the steady stretch.
	always @(posedge clk) begin
		out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 22);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending",
				cycle_count, pending_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// One slot word, preceded by random idle cycles; returns once accepted.
	task automatic send_slot(input int idx, input int cnt, input bit on);
		while (!no_gaps && $urandom_range(0, 99) < 22) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.sample_index <= IDX_W'(idx);
		in_ch.frame_count  <= CNT_W'(cnt);
		in_ch.wave_on      <= on;
		do @(posedge clk); while (!in_ch.ready);
		slots_sent++;
	endtask

	// Park the slot side and wait until every predicted word has come out.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	// Both registers, written back to back while the block is idle.
	task automatic write_settings(input logic [31:0] step, input logic [15:0] gain);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PHASE_STEP;
		cfg_wdata <= step;
		@(posedge clk);
		cfg_index <= REG_AMPLITUDE;
		cfg_wdata <= CFG_W'(gain);
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings_used++;
	endtask

	// Mostly whole blocks with random sizes and on/off changes, some cut
	// short or flipped midway, and some lone slots with arbitrary fields.
	task automatic send_random_blocks(input int budget);
		int first;
		int pick;
		int cnt;
		int len;
		bit on;
		first = slots_sent;
		on    = ($urandom_range(0, 1) == 1);
		while (slots_sent - first < budget) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 40) begin
				on = !on;
			end
			if (pick < 80) begin
				len = $urandom_range(0, 99);
				cnt = (len < 75) ? $urandom_range(1, 12) :
					(len < 95) ? $urandom_range(13, 64) : $urandom_range(65, 1024);
				if (cnt <= 64) begin
					for (int k = 0; k < cnt; k++) begin
						send_slot(k, cnt, on);
					end
				end else begin
					// Long blocks: only the opening and closing slots.
					for (int k = 0; k < 4; k++) begin
						send_slot(k, cnt, on);
					end
					for (int k = cnt - 4; k < cnt; k++) begin
						send_slot(k, cnt, on);
					end
				end
			end else if (pick < 90) begin
				cnt = $urandom_range(2, 16);
				len = $urandom_range(1, cnt - 1);
				for (int k = 0; k < len; k++) begin
					send_slot(k, cnt, on);
				end
				if ($urandom_range(0, 1)) begin
					for (int k = len; k < cnt; k++) begin
						send_slot(k, cnt, !on);
					end
				end
			end else begin
				send_slot($urandom_range(0, 1023), $urandom_range(0, 2047),
					($urandom_range(0, 1) == 1));
			end
		end
	endtask

	// Main sequence.
	initial begin
		logic [31:0] step;
		logic [15:0] gain;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed blocks: fade in, steady tone, fade out, muted, and the
		// odd counts and indexes.
		write_settings(32'h0A3D_70A4, 16'd32768);
		for (int k = 0; k < 4; k++) send_slot(k, 4, 1'b1);
		for (int k = 0; k < 3; k++) send_slot(k, 3, 1'b1);
		for (int k = 0; k < 4; k++) send_slot(k, 4, 1'b0);
		for (int k = 0; k < 2; k++) send_slot(k, 2, 1'b0);
		// Zero count on, then an index past the count, then the last slot.
		send_slot(0, 0, 1'b1);
		send_slot(5, 2, 1'b1);
		send_slot(1, 2, 1'b1);
		// Falling ramp with the widest count, a zero count and an index past it.
		send_slot(1023, 2047, 1'b0);
		send_slot(0, 0, 1'b0);
		send_slot(7, 3, 1'b0);
		send_slot(0, 1, 1'b0);
		// Rising ramp over the longest block.
		send_slot(0, 1024, 1'b1);
		send_slot(511, 1024, 1'b1);
		send_slot(1023, 1024, 1'b1);

		// Random phases, each under its own register setting.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin step = 32'hFFFF_FFFF; gain = 16'd0;     end
				1: begin step = 32'h0000_0000; gain = 16'd32768; end
				2: begin step = 32'h4000_0000; gain = 16'hFFFF;  end
				3: begin step = $urandom;      gain = 16'($urandom_range(0, 32768)); end
				4: begin step = 32'h0100_0000; gain = 16'd16384; end
				5: begin step = $urandom;      gain = 16'($urandom_range(0, 32768)); end
				6: begin step = 32'h8000_0001; gain = 16'd1;     end
				default: begin step = $urandom; gain = 16'd32768; end
			endcase
			write_settings(step, gain);
			no_gaps <= (p == 3);
			send_random_blocks(SLOTS_PER_PHASE);
		end
		no_gaps <= 1'b0;

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run sent %0d slot words under %0d register settings.",
			slots_sent, settings_used);
		$display("Checked %0d sample words, %0d of them on a fade ramp.",
			words_checked, ramp_words);
		if (fail_count == 0 && pending_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sofu_pkg.sv
rtl/sofu_channels.sv
rtl/sofu_datapath.sv
rtl/sofu_ctrl.sv
rtl/sine_oscillator_with_fade_unit.sv
dv/sofu_sample_checker.sv
dv/tb_sine_oscillator_with_fade_unit.sv
